FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the point ring block.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(name, expr, msg) \
    `ASSERT_CLK(name, !(expr), msg)

`endif

FILE: hdl/prl_pkg.sv
// Shared types and constants of the point ring list manager.
// Used by point_ring_list_manager; depends on nothing.
package prl_pkg;

    // Default sizes of the slot pool and of a stored coordinate.
    localparam int PRL_POOL_SLOTS = 256;
    localparam int PRL_COORD_BITS = 16;

    // The free map is kept as words of this many slot bits.
    localparam int MAP_BITS  = 32;
    localparam int MAP_SHIFT = 5;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_NEXT   = 2'd2,
        OP_PREV   = 2'd3
    } op_t;

    // Result status carried in m_tuser.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_LINK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ADD_W1,
        ST_ADD_W2,
        ST_DEL_RD,
        ST_DEL_FREE,
        ST_DEL_LINK,
        ST_MOVE_RD,
        ST_MOVE_CAP,
        ST_XY_RD,
        ST_RESULT
    } state_t;

endpackage

FILE: hdl/prl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module prl_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/point_ring_list_manager.sv
// Point ring list manager: a ring of points in a fixed slot pool with a cursor.
// Depends on prl_pkg, prl_ram and assert_macros.svh.
//
// Usage: each input beat on the s_ channel is one operation, selected by
// s_tuser (add point, delete current, move next, move previous); s_tdata
// carries the point for an add. Every operation returns exactly one result
// beat on the m_ channel with the status in m_tuser and the cursor point,
// its slot and the point count in m_tdata.
// Steps, one after the other: a move reads the next or previous link, takes
// it as the cursor and reads the point (only the point when the ring has
// fewer than two points); a delete reads the links and map word, frees the
// slot, relinks the neighbours (not for the last point) and reads the point;
// an add scans free-map words, writes the point, map and links, completes
// the links (not on an empty ring) and reads the point; a refused add or
// delete only reads the point. One operation is in work at a time;
// s_tready is high again in the cycle after the result is loaded. The output
// register lets the next item be accepted while a result still waits; if
// m_tready stays low the sequencer holds the following result. After reset
// the free map is cleared to all free, one word a cycle, with s_tready low.
`include "assert_macros.svh"

module point_ring_list_manager
    import prl_pkg::*;
#(
    parameter int POOL_SLOTS = PRL_POOL_SLOTS,
    parameter int COORD_BITS = PRL_COORD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pt_x [15:0], pt_y [31:16]
    input  logic [1:0]  s_tuser,   // op [1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // cur_x [15:0], cur_y [31:16], cur_slot [39:32],
                                   // point_count [48:40], zero [55:49]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int SW     = $clog2(POOL_SLOTS);
    localparam int CW     = SW + 1;
    localparam int NWORDS = (POOL_SLOTS + MAP_BITS - 1) / MAP_BITS;
    localparam int WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int XYW    = 2 * COORD_BITS;

    // Sequencer and control registers.
    state_t                state_reg, state_next;
    logic [SW-1:0]         cursor_reg;
    logic [CW-1:0]         count_reg;
    logic [WAW-1:0]        hint_reg;
    logic [WAW-1:0]        scan_reg;
    logic [WAW-1:0]        clr_reg;
    logic                  m_tvalid_reg;

    // Payload registers.
    op_t                   op_reg;
    status_t               status_reg;
    logic signed [15:0]    pt_x_reg, pt_y_reg;
    logic [SW-1:0]         where_reg, before_reg, after_reg;
    logic [MAP_BITS-1:0]   word_reg;
    logic [55:0]           m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    // RAM ports.
    logic                  xy_we, xy_re;
    logic [SW-1:0]         xy_waddr, xy_raddr;
    logic [XYW-1:0]        xy_wdata, xy_rdata;
    logic                  nl_we, nl_re;
    logic [SW-1:0]         nl_waddr, nl_raddr, nl_wdata, nl_rdata;
    logic                  pl_we, pl_re;
    logic [SW-1:0]         pl_waddr, pl_raddr, pl_wdata, pl_rdata;
    logic                  fm_we, fm_re;
    logic [WAW-1:0]        fm_waddr, fm_raddr;
    logic [MAP_BITS-1:0]   fm_wdata, fm_rdata;

    // Helper signals.
    op_t                   op_in;
    logic [SW+MAP_SHIFT-1:0] cur_ext;
    logic [WAW-1:0]        cur_word;
    logic [MAP_SHIFT-1:0]  cur_bit;
    logic                  free_hit;
    logic [MAP_SHIFT-1:0]  free_bit;
    logic [COORD_BITS-1:0] x_st, y_st;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [15:0]           res_x, res_y;
    logic [7:0]            res_slot;
    logic [8:0]            res_count;
    logic                  out_free;
    logic                  pool_full, ring_empty, ring_short;

    // Coordinate storage, slot links and the free map.
    prl_ram #(.WIDTH(XYW), .DEPTH(POOL_SLOTS)) u_xy_ram (
        .aclk(aclk), .wr_en(xy_we), .wr_addr(xy_waddr), .wr_data(xy_wdata),
        .rd_en(xy_re), .rd_addr(xy_raddr), .rd_data(xy_rdata)
    );

    prl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_next_ram (
        .aclk(aclk), .wr_en(nl_we), .wr_addr(nl_waddr), .wr_data(nl_wdata),
        .rd_en(nl_re), .rd_addr(nl_raddr), .rd_data(nl_rdata)
    );

    prl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_prev_ram (
        .aclk(aclk), .wr_en(pl_we), .wr_addr(pl_waddr), .wr_data(pl_wdata),
        .rd_en(pl_re), .rd_addr(pl_raddr), .rd_data(pl_rdata)
    );

    prl_ram #(.WIDTH(MAP_BITS), .DEPTH(NWORDS)) u_free_ram (
        .aclk(aclk), .wr_en(fm_we), .wr_addr(fm_waddr), .wr_data(fm_wdata),
        .rd_en(fm_re), .rd_addr(fm_raddr), .rd_data(fm_rdata)
    );

    // Decoded input and ring conditions.
    assign op_in      = op_t'(s_tuser);
    assign pool_full  = count_reg >= CW'(POOL_SLOTS);
    assign ring_empty = count_reg == '0;
    assign ring_short = count_reg < CW'(2);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Free-map word and bit of the cursor slot.
    assign cur_ext  = {{MAP_SHIFT{1'b0}}, cursor_reg};
    assign cur_word = WAW'(cur_ext >> MAP_SHIFT);
    assign cur_bit  = cur_ext[MAP_SHIFT-1:0];

    // Lowest free slot in the free-map word just read.
    always_comb begin
        free_hit = |fm_rdata;
        free_bit = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--) begin
            if (fm_rdata[i]) begin
                free_bit = MAP_SHIFT'(i);
            end
        end
    end

    // A point is stored in COORD_BITS bits and read back sign-extended.
    assign x_st  = COORD_BITS'(32'(pt_x_reg));
    assign y_st  = COORD_BITS'(32'(pt_y_reg));
    assign rd_x  = xy_rdata[COORD_BITS-1:0];
    assign rd_y  = xy_rdata[XYW-1:COORD_BITS];

    // Result fields; an empty ring reports zeros.
    always_comb begin
        if (ring_empty) begin
            res_x    = '0;
            res_y    = '0;
            res_slot = '0;
        end else begin
            res_x    = 16'(32'(rd_x));
            res_y    = 16'(32'(rd_y));
            res_slot = 8'({8'd0, cursor_reg});
        end
        res_count = 9'({9'd0, count_reg});
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == WAW'(NWORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (op_in)
                        OP_ADD:    state_next = pool_full ? ST_XY_RD : ST_ADD_LINK;
                        OP_DELETE: state_next = ring_empty ? ST_XY_RD : ST_DEL_RD;
                        default:   state_next = ring_short ? ST_XY_RD : ST_MOVE_RD;
                    endcase
                end
            end
            ST_ADD_LINK: state_next = ST_SCAN_CHK;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = free_hit ? ST_ADD_W1 : ST_SCAN_RD;
            ST_ADD_W1:   state_next = ring_empty ? ST_XY_RD : ST_ADD_W2;
            ST_ADD_W2:   state_next = ST_XY_RD;
            ST_DEL_RD:   state_next = ST_DEL_FREE;
            ST_DEL_FREE: state_next = (count_reg == CW'(1)) ? ST_XY_RD : ST_DEL_LINK;
            ST_DEL_LINK: state_next = ST_XY_RD;
            ST_MOVE_RD:  state_next = ST_MOVE_CAP;
            ST_MOVE_CAP: state_next = ST_XY_RD;
            ST_XY_RD:    state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // RAM accesses issued in each state.
    always_comb begin
        xy_we = 1'b0; xy_waddr = where_reg; xy_wdata = {y_st, x_st};
        xy_re = 1'b0; xy_raddr = cursor_reg;
        nl_we = 1'b0; nl_waddr = where_reg; nl_wdata = where_reg;
        nl_re = 1'b0; nl_raddr = cursor_reg;
        pl_we = 1'b0; pl_waddr = where_reg; pl_wdata = where_reg;
        pl_re = 1'b0; pl_raddr = cursor_reg;
        fm_we = 1'b0; fm_waddr = scan_reg; fm_wdata = word_reg;
        fm_re = 1'b0; fm_raddr = scan_reg;
        case (state_reg)
            ST_CLEAR: begin
                fm_we    = 1'b1;
                fm_waddr = clr_reg;
                fm_wdata = '1;
            end
            ST_ADD_LINK: begin
                nl_re    = 1'b1;
                fm_re    = 1'b1;
                fm_raddr = hint_reg;
            end
            ST_SCAN_RD: begin
                fm_re = 1'b1;
            end
            ST_ADD_W1: begin
                xy_we = 1'b1;
                fm_we = 1'b1;
                nl_we = 1'b1;
                pl_we = 1'b1;
                // A first point links to itself; otherwise splice after the cursor.
                if (!ring_empty) begin
                    nl_waddr = cursor_reg;
                    pl_waddr = nl_rdata;
                end
            end
            ST_ADD_W2: begin
                nl_we    = 1'b1;
                nl_wdata = after_reg;
                pl_we    = 1'b1;
                pl_wdata = cursor_reg;
            end
            ST_DEL_RD: begin
                nl_re    = 1'b1;
                pl_re    = 1'b1;
                fm_re    = 1'b1;
                fm_raddr = cur_word;
            end
            ST_DEL_FREE: begin
                fm_we    = 1'b1;
                fm_waddr = cur_word;
                fm_wdata = fm_rdata | (MAP_BITS'(1) << cur_bit);
            end
            ST_DEL_LINK: begin
                nl_we    = 1'b1;
                nl_waddr = before_reg;
                nl_wdata = after_reg;
                pl_we    = 1'b1;
                pl_waddr = after_reg;
                pl_wdata = before_reg;
            end
            ST_MOVE_RD: begin
                nl_re = (op_reg == OP_NEXT);
                pl_re = (op_reg != OP_NEXT);
            end
            ST_XY_RD: begin
                xy_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cursor_reg   <= '0;
            count_reg    <= '0;
            hint_reg     <= '0;
            scan_reg     <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A new result takes the output register as the old beat leaves.
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + WAW'(1);
                end
                ST_ADD_LINK: begin
                    scan_reg <= hint_reg;
                end
                ST_SCAN_CHK: begin
                    // Words below the hint hold no free slot.
                    if (free_hit) begin
                        hint_reg <= scan_reg;
                    end else begin
                        scan_reg <= scan_reg + WAW'(1);
                    end
                end
                ST_ADD_W1: begin
                    if (ring_empty) begin
                        cursor_reg <= where_reg;
                        count_reg  <= count_reg + CW'(1);
                    end
                end
                ST_ADD_W2: begin
                    cursor_reg <= where_reg;
                    count_reg  <= count_reg + CW'(1);
                end
                ST_DEL_FREE: begin
                    count_reg <= count_reg - CW'(1);
                    if (cur_word < hint_reg) begin
                        hint_reg <= cur_word;
                    end
                    // The last point gone sends the cursor back to slot zero.
                    if (count_reg == CW'(1)) begin
                        cursor_reg <= '0;
                    end
                end
                ST_DEL_LINK: begin
                    cursor_reg <= before_reg;
                end
                ST_MOVE_CAP: begin
                    cursor_reg <= (op_reg == OP_NEXT) ? nl_rdata : pl_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_reg   <= op_in;
                    pt_x_reg <= s_tdata[15:0];
                    pt_y_reg <= s_tdata[31:16];
                    if (op_in == OP_ADD && pool_full) begin
                        status_reg <= STAT_FULL;
                    end else if (op_in == OP_DELETE && ring_empty) begin
                        status_reg <= STAT_EMPTY;
                    end else begin
                        status_reg <= STAT_OK;
                    end
                end
            end
            ST_SCAN_CHK: begin
                where_reg <= SW'({scan_reg, free_bit});
                word_reg  <= fm_rdata & ~(MAP_BITS'(1) << free_bit);
            end
            ST_ADD_W1: begin
                after_reg <= nl_rdata;
            end
            ST_DEL_FREE: begin
                before_reg <= pl_rdata;
                after_reg  <= nl_rdata;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_tdata_reg <= {7'd0, res_count, res_slot, res_y, res_x};
                    m_tuser_reg <= status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Ports.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on the sequencer and the ring bookkeeping.
    `ASSERT_CLK(a_count_bound, count_reg <= CW'(POOL_SLOTS), "ring count above pool size")
    `ASSERT_CLK(a_busy_after_beat, s_tvalid && s_tready |=> !s_tready, "second beat taken while busy")
    `ASSERT_CLK(a_empty_result, m_tvalid && (m_tuser == STAT_EMPTY) |-> m_tdata[48:0] == '0, "refused delete on a nonempty ring")
    `ASSERT_NEVER(a_scan_range, (state_reg == ST_SCAN_CHK) && (32'(scan_reg) >= NWORDS), "free-map scan ran past the pool")

endmodule
